/* design/mtg_pkg.sv */
// ----------------------------------------------------------------------------
// mtg_pkg: shared types and constants of the MT19937 generator
// Holds table geometry, the command word and the generator constants.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int TABLE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int TWIST_BACK   = TABLE_WORDS - TWIST_OFFSET;
  localparam int IDX_W        = $clog2(TABLE_WORDS);
  localparam int WORD_W       = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam idx_t LAST_IDX = idx_t'(TABLE_WORDS - 1);

  // command codes carried in the opcode field
  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  localparam word_t MATRIX_A   = 32'h9908_B0DF;
  localparam word_t SEED_MULT  = 32'd1812433253;
  localparam word_t UPPER_MASK = 32'h8000_0000;
  localparam word_t LOWER_MASK = 32'h7FFF_FFFF;
  localparam word_t TEMPER_B   = 32'h9D2C_5680;
  localparam word_t TEMPER_C   = 32'hEFC6_0000;

  typedef struct packed {
    logic  opcode;
    word_t seed;
  } cmd_t;

endpackage

/* design/mt19937_generator_core.sv */
// ----------------------------------------------------------------------------
// mt19937_generator_core: MT19937 pseudo-random word generator
// Reseed and draw commands in, tempered 32-bit words out.
// ----------------------------------------------------------------------------
// Draw path: a draw leaves the front queue in S_IDLE, where the registered
//   table read starts, and is twisted, written back and tempered in S_DRAW.
// Commands are taken only in S_IDLE, a draw only when the output slot is free.
// Reseed: the multiply-then-add seed recurrence, S_SEED_MUL then S_SEED_ADD.
// Reset: no table clearing pass; an unseeded flag returns zero words until
//   the first reseed, exactly as an all-zero table would.
module mt19937_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  // command stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed
  input  logic [0:0]  in_tuser,   // [0] opcode: 0 reseed, 1 draw
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] random_word
);
  import mtg_pkg::*;

  cmd_t  in_cmd;
  cmd_t  q_cmd;
  logic  q_valid;
  logic  q_ready;
  word_t out_word;

  // split the stream word into the command fields
  assign in_cmd.opcode = in_tuser[0];
  assign in_cmd.seed   = in_tdata;

  // front: hold commands in a short queue; the input waits only while it is full
  mtg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_cmd),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  // back: seed fill, per-draw twist of one table word, tempering, output register
  mtg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = out_word;

endmodule

/* design/mtg_ram.sv */
// ----------------------------------------------------------------------------
// mtg_ram: generic RAM, one write port and two registered read ports
// Read data appears in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

/* design/mtg_front.sv */
// ----------------------------------------------------------------------------
// mtg_front: input side of the generator
// Two-entry command queue between the input stream and the execution side.
// ----------------------------------------------------------------------------
module mtg_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mtg_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_ready,
  output mtg_pkg::cmd_t q_cmd
);
  import mtg_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_cmd    = ent_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

/* design/mtg_back.sv */
// ----------------------------------------------------------------------------
// mtg_back: execution side of the generator
// Seeds the word table, twists one word per draw and tempers the result.
// ----------------------------------------------------------------------------
module mtg_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  mtg_pkg::cmd_t        cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mtg_pkg::word_t       out_word
);
  import mtg_pkg::*;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DRAW     = 2'd1;
  localparam logic [1:0] S_SEED_MUL = 2'd2;
  localparam logic [1:0] S_SEED_ADD = 2'd3;

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  logic [1:0] state_r, state_nxt;
  idx_t       pos_r, pos_nxt;
  idx_t       seed_idx_r, seed_idx_nxt;
  logic       unseeded_r, unseeded_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_data_r, out_data_nxt;
  word_t      last_r, last_nxt;
  word_t      prod_r, prod_nxt;
  word_t      cache_r, cache_nxt;

  logic       mem_we;
  idx_t       mem_waddr;
  word_t      mem_wdata;
  idx_t       rd_nxt_addr, rd_far_addr;
  word_t      rd_nxt_word, rd_far_word;

  idx_t       pos_inc;
  logic       out_free;
  logic       take;
  word_t      y_word, twisted, mix, seed_word;

  mtg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_WORDS)
  ) u_table (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (rd_nxt_addr),
    .rdata_a (rd_nxt_word),
    .raddr_b (rd_far_addr),
    .rdata_b (rd_far_word)
  );

  assign pos_inc     = (pos_r == LAST_IDX) ? '0 : pos_r + idx_t'(1);
  assign rd_nxt_addr = pos_inc;
  assign rd_far_addr = (pos_r < idx_t'(TWIST_BACK)) ? pos_r + idx_t'(TWIST_OFFSET)
                                                   : pos_r - idx_t'(TWIST_BACK);

  // the output slot is free now or frees at this edge
  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && ((cmd.opcode == OP_RESEED) || out_free);
  assign take      = cmd_valid && cmd_ready;

  assign y_word    = (cache_r & UPPER_MASK) | (rd_nxt_word & LOWER_MASK);
  assign twisted   = rd_far_word ^ (y_word >> 1) ^ (y_word[0] ? MATRIX_A : '0);
  assign mix       = last_r ^ (last_r >> 30);
  assign seed_word = prod_r + word_t'(seed_idx_r);

  assign out_valid = out_valid_r;
  assign out_word  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    seed_idx_nxt  = seed_idx_r;
    unseeded_nxt  = unseeded_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    cache_nxt     = cache_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = twisted;

    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (cmd.opcode == OP_RESEED) begin
            mem_we       = 1'b1;
            mem_waddr    = '0;
            mem_wdata    = cmd.seed;
            last_nxt     = cmd.seed;
            cache_nxt    = cmd.seed;
            seed_idx_nxt = idx_t'(1);
            state_nxt    = S_SEED_MUL;
          end else begin
            state_nxt = S_DRAW;
          end
        end
      end
      S_DRAW: begin
        // table words next and far were read last cycle; write back word pos
        mem_we        = !unseeded_r;
        mem_waddr     = pos_r;
        mem_wdata     = twisted;
        out_valid_nxt = 1'b1;
        out_data_nxt  = unseeded_r ? '0 : temper(twisted);
        cache_nxt     = rd_nxt_word;
        pos_nxt       = pos_inc;
        state_nxt     = S_IDLE;
      end
      S_SEED_MUL: begin
        prod_nxt  = mix * SEED_MULT;
        state_nxt = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        mem_we    = 1'b1;
        mem_waddr = seed_idx_r;
        mem_wdata = seed_word;
        last_nxt  = seed_word;
        if (seed_idx_r == LAST_IDX) begin
          unseeded_nxt = 1'b0;
          pos_nxt      = '0;
          state_nxt    = S_IDLE;
        end else begin
          seed_idx_nxt = seed_idx_r + idx_t'(1);
          state_nxt    = S_SEED_MUL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      seed_idx_r  <= '0;
      unseeded_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      seed_idx_r  <= seed_idx_nxt;
      unseeded_r  <= unseeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    last_r     <= last_nxt;
    prod_r     <= prod_nxt;
    cache_r    <= cache_nxt;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_IDX)
    else $error("read position beyond table");

  a_draw_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAW |=> out_valid_r)
    else $error("draw finished without a result");

  a_draw_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd.opcode == OP_DRAW) |-> (!out_valid_r || out_ready))
    else $error("draw started while output slot busy");

  a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEED_ADD && seed_idx_r == LAST_IDX) |=> (!unseeded_r && pos_r == '0))
    else $error("seed fill did not arm the generator");

  a_no_write_unseeded_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW && unseeded_r) |-> !mem_we)
    else $error("table written on an unseeded draw");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the MT19937 generator core
// Streams reseed and draw words into the core and predicts every tempered
// output word with a table model of its own. Covers unseeded draws, extreme
// seeds, reseeds between draws, a long seeded run across the table wrap and
// random command mixes under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import mtg_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // [31:0] seed
  logic [0:0]  in_tuser = '0;    // [0] opcode: 0 reseed, 1 draw
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [31:0] random_word

  // Commands waiting for the driver, and words the core still owes us.
  cmd_t  pending_cmds[$];
  word_t owed_words[$];

  // Shadow copy of the generator state.
  word_t gen_table [TABLE_WORDS];
  int    gen_pos;

  // Idle percentages for the current phase, and the long receiver hold-off.
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  bit    hold_req = 1'b0;
  int    hold_left = 0;
  int    errors = 0;

  mt19937_generator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Generator model
  // ---------------------------------------------------------------------------
  function automatic word_t temper_word(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Fill the table from a seed with the multiply-xor-shift recurrence.
  task automatic load_seed(input word_t s);
    word_t prev;
    prev = s;
    gen_table[0] = s;
    for (int j = 1; j < TABLE_WORDS; j++) begin
      prev = SEED_MULT * (prev ^ (prev >> 30)) + word_t'(j);
      gen_table[j] = prev;
    end
    // force a twist ahead of the next draw
    gen_pos = TABLE_WORDS;
  endtask

  task automatic twist_table();
    word_t y;
    word_t v;
    for (int i = 0; i < TABLE_WORDS; i++) begin
      y = (gen_table[i] & UPPER_MASK) | (gen_table[(i + 1) % TABLE_WORDS] & LOWER_MASK);
      v = gen_table[(i + TWIST_OFFSET) % TABLE_WORDS] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ MATRIX_A;
      end
      gen_table[i] = v;
    end
  endtask

  // Advance the model by one accepted command; queue the word a draw owes.
  task automatic apply_cmd(input cmd_t c);
    if (c.opcode == OP_RESEED) begin
      load_seed(c.seed);
    end else begin
      if (gen_pos >= TABLE_WORDS) begin
        twist_table();
        gen_pos = 0;
      end
      owed_words.push_back(temper_word(gen_table[gen_pos]));
      gen_pos++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hold the word until accepted, then predict it and offer the next
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_cmds
    cmd_t c;
    logic next_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_cmd(cmd_t'{opcode: in_tuser[0], seed: in_tdata});
      end
      if (!in_tvalid || in_tready) begin
        next_valid = 1'b0;
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          in_tdata <= c.seed;
          in_tuser <= c.opcode;
          next_valid = 1'b1;
        end
        // one assignment per step, so a back-to-back word keeps valid high
        in_tvalid <= next_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted word with the oldest owed word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_words
    word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %08h", $time, out_tdata);
        errors++;
      end else begin
        want = owed_words.pop_front();
        if (out_tdata !== want) begin
          $display("%0t: random_word mismatch, expected %08h, got %08h",
                   $time, want, out_tdata);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_reseed(input word_t s);
    pending_cmds.push_back(cmd_t'{opcode: OP_RESEED, seed: s});
  endtask

  // The seed field rides along on a draw and must be ignored.
  task automatic push_draws(input int n);
    for (int k = 0; k < n; k++) begin
      pending_cmds.push_back(cmd_t'{opcode: OP_DRAW, seed: word_t'($urandom)});
    end
  endtask

  function automatic word_t pick_seed();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Mostly reseed-then-draw runs; the rest lone draws and bare reseeds.
  task automatic queue_mix(input int n_items);
    int done;
    int r;
    int k;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        k = $urandom_range(1, 30);
        push_reseed(pick_seed());
        push_draws(k);
        done += k + 1;
      end else if (r < 90) begin
        k = $urandom_range(1, 5);
        push_draws(k);
        done += k;
      end else begin
        push_reseed(pick_seed());
        done++;
      end
    end
  endtask

  // Pause the sender until the core has handed back every owed word.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_tvalid || owed_words.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < TABLE_WORDS; i++) begin
      gen_table[i] = '0;
    end
    gen_pos = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Unseeded: draw from the zero table.
    pending_cmds.push_back(cmd_t'{opcode: OP_DRAW, seed: 32'h0000_0000});
    pending_cmds.push_back(cmd_t'{opcode: OP_DRAW, seed: 32'hFFFF_FFFF});
    push_draws(38);
    wait_drained();

    // Directed: extreme seeds, reseed between draws, back-to-back reseeds.
    push_reseed(32'h0000_0000);
    pending_cmds.push_back(cmd_t'{opcode: OP_DRAW, seed: 32'h0000_0000});
    pending_cmds.push_back(cmd_t'{opcode: OP_DRAW, seed: 32'hFFFF_FFFF});
    push_draws(1);
    push_reseed(32'hFFFF_FFFF);
    push_draws(2);
    push_reseed(32'd5489);
    push_draws(3);
    push_reseed(32'h0000_0001);
    push_draws(1);
    push_reseed(32'h8000_0000);
    push_draws(2);
    push_reseed(32'h1234_5678);
    push_reseed(32'h7FFF_FFFF);
    push_draws(2);
    wait_drained();

    // No idling: stall the receiver long while the sender keeps offering
    // draws, then run one seeded stream across the table wrap.
    @(negedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    push_draws(8);
    push_reseed(pick_seed());
    push_draws($urandom_range(TABLE_WORDS + 1, TABLE_WORDS + 60));
    queue_mix(60);
    wait_drained();

    set_idle(83, 0);
    queue_mix(100);
    wait_drained();

    set_idle(0, 83);
    queue_mix(100);
    wait_drained();

    set_idle(27, 27);
    queue_mix(100);
    wait_drained();

    // Let a trailing reseed run out, watching for stray words.
    set_idle(0, 0);
    repeat (1400) @(posedge clk);

    if (owed_words.size() != 0) begin
      $display("%0t: %0d words never arrived, expected %08h, got none",
               $time, owed_words.size(), owed_words[0]);
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
design/mtg_pkg.sv
design/mtg_ram.sv
design/mtg_front.sv
design/mtg_back.sv
design/mt19937_generator_core.sv
verif/tb_top.sv
